### hdl/tmrc_pkg.sv
// tmrc_pkg: types and constants for the tile map rectangle collision block
// used by tile_map_rect_collision; no dependencies
package tmrc_pkg;

  localparam int MAX_COLS_DEF    = 64;
  localparam int MAX_ROWS_DEF    = 64;
  localparam int TILE_SIZE_RESET = 32;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register indexes, paddr[3:2]
  localparam logic [1:0] REG_TILE_SIZE = 2'd0;
  localparam logic [1:0] REG_MAP_COLS  = 2'd1;
  localparam logic [1:0] REG_MAP_ROWS  = 2'd2;

  // item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // divider lanes
  localparam int LANES     = 4;
  localparam int LN_LEFT   = 0;
  localparam int LN_RIGHT  = 1;
  localparam int LN_TOP    = 2;
  localparam int LN_BOTTOM = 3;
  localparam int DVD_W     = 16;
  localparam int QW        = DVD_W + 1;
  localparam int DVS_W     = 9;

  localparam int IN_DW  = 88;
  localparam int OUT_DW = 8;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_WR_WB,
    ST_DIV,
    ST_CLIP,
    ST_SCAN,
    ST_DONE
  } st_t;

endpackage

### hdl/tile_map_rect_collision.sv
// tile_map_rect_collision: tile solid map with rectangle collision queries
// depends on tmrc_pkg
//
// usage: items enter on the in_ stream, one result item per input item leaves
// on the out_ stream (out_tdata[0] = hit). in_tuser is the kind: 0 writes the
// solid mark of one tile, 1 queries a rectangle. config registers (tile_size,
// map_columns, map_rows) sit on the cfg_ port at byte addresses 0, 4, 8.
// the map is a row-wide memory: one entry per tile row, one bit per column.
// a write item reads its row at acceptance and writes it back the next cycle.
// a query runs four 16-step shift-subtract divisions in parallel, clips the
// covered range, then reads one covered row per cycle through the single
// read port, stopping at the first hit.
// one item is worked on at a time; the next item is taken while a result
// waits in the output register, and a stalled receiver holds the block only
// once a second result is ready.
// after reset a clearing pass writes every row to empty with in_tready low;
// config writes are taken throughout.
module tile_map_rect_collision #(
  parameter int MAX_COLS = tmrc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = tmrc_pkg::MAX_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tile_col, tile_row, tile_id, rect_x, rect_y, rect_w, rect_h
  input  logic [tmrc_pkg::IN_DW-1:0]    in_tdata,
  // kind
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // hit
  output logic [tmrc_pkg::OUT_DW-1:0]   out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tmrc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [tmrc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [tmrc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import tmrc_pkg::*;

  localparam int CA_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RA_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int MAXD  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int CNT_W = $clog2(MAXD + 1) + 1;
  localparam int CMPW  = ((CNT_W > QW) ? CNT_W : QW) + 1;
  localparam int DC_W  = $clog2(DVD_W);

  // config registers
  logic [8:0] tile_size_r;
  logic [6:0] map_cols_r;
  logic [6:0] map_rows_r;
  logic       cfg_wr;

  // control
  st_t              st_r, st_nxt;
  logic [RA_W:0]    clr_r;
  logic [DC_W-1:0]  dcnt_r;

  // memory
  logic [MAX_COLS-1:0] mem [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_r;
  logic                mem_re, mem_we;
  logic [RA_W-1:0]     mem_raddr, mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;

  // write item
  logic [RA_W-1:0]     wrow_r;
  logic [MAX_COLS-1:0] wmask_r, wmask;
  logic                wsolid_r, wvalid_r;

  // divider lanes
  logic [DVD_W-1:0] dvd_r [LANES];
  logic [DVD_W-1:0] dvd_nxt [LANES];
  logic [DVS_W-1:0] rem_r [LANES];
  logic [DVS_W-1:0] rem_nxt [LANES];
  logic             neg_r [LANES];
  logic [DVS_W-1:0] ts_r;
  logic signed [QW-1:0] a_in [LANES];

  // clipped range and scan
  logic signed [CMPW-1:0] q_s [LANES];
  logic signed [CMPW-1:0] cols_s, rows_s;
  logic signed [CMPW-1:0] left_c, right_c, top_c, bottom_c;
  logic                   empty_c;
  logic [CA_W-1:0]        left_r, right_r;
  logic [RA_W-1:0]        top_r, bottom_r;
  logic                   empty_r;
  logic [RA_W:0]          row_r;
  logic                   issue, issued_r, hit_r;
  logic [MAX_COLS-1:0]    scan_mask;

  // output register
  logic out_valid_r, out_hit_r, out_load;
  // marks whether the item in flight is a query
  logic last_query_r;

  // input fields
  logic [5:0]         in_tile_col, in_tile_row;
  logic signed [15:0] in_tile_id, in_rect_x, in_rect_y;
  logic [11:0]        in_rect_w, in_rect_h;
  logic               accept;

  assign in_tile_col = in_tdata[5:0];
  assign in_tile_row = in_tdata[11:6];
  assign in_tile_id  = in_tdata[27:12];
  assign in_rect_x   = in_tdata[43:28];
  assign in_rect_y   = in_tdata[59:44];
  assign in_rect_w   = in_tdata[71:60];
  assign in_rect_h   = in_tdata[83:72];
  assign accept      = in_tvalid && in_tready;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_size_r <= 9'(TILE_SIZE_RESET);
      map_cols_r  <= '0;
      map_rows_r  <= '0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_TILE_SIZE: tile_size_r <= cfg_pwdata[8:0];
        REG_MAP_COLS:  map_cols_r  <= cfg_pwdata[6:0];
        REG_MAP_ROWS:  map_rows_r  <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_TILE_SIZE: cfg_prdata = CFG_DW'(tile_size_r);
      REG_MAP_COLS:  cfg_prdata = CFG_DW'(map_cols_r);
      REG_MAP_ROWS:  cfg_prdata = CFG_DW'(map_rows_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_CLR:   if (clr_r == (RA_W+1)'(MAX_ROWS - 1)) st_nxt = ST_IDLE;
      ST_IDLE:  if (accept) st_nxt = (in_tuser == KIND_QUERY) ? ST_DIV : ST_WR_WB;
      ST_WR_WB: st_nxt = ST_DONE;
      ST_DIV:   if (dcnt_r == DC_W'(DVD_W - 1)) st_nxt = ST_CLIP;
      ST_CLIP:  st_nxt = empty_c ? ST_DONE : ST_SCAN;
      ST_SCAN:  if (!issue && !issued_r) st_nxt = ST_DONE;
      ST_DONE:  if (out_load) st_nxt = ST_IDLE;
      default:  st_nxt = ST_CLR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    in_tready = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    out_load  = 1'b0;
    case (st_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r[RA_W-1:0];
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_re    = accept;
        mem_raddr = RA_W'(in_tile_row);
      end
      ST_WR_WB: begin
        mem_we    = wvalid_r;
        mem_waddr = wrow_r;
        mem_wdata = (rdata_r & ~wmask_r) | (wsolid_r ? wmask_r : '0);
      end
      ST_SCAN: begin
        mem_re    = issue;
        mem_raddr = row_r[RA_W-1:0];
      end
      ST_DONE: out_load = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_CLR;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (st_r == ST_CLR) clr_r <= clr_r + 1'b1;
    end
  end

  // row memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rdata_r <= mem[mem_raddr];
  end

  // write item capture
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      wmask[i] = (CMPW'(i) == CMPW'(in_tile_col));
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_tuser == KIND_WRITE) begin
      wrow_r   <= RA_W'(in_tile_row);
      wmask_r  <= wmask;
      wsolid_r <= (in_tile_id != 16'sd0);
      wvalid_r <= (CMPW'(in_tile_col) < CMPW'(MAX_COLS)) &&
                  (CMPW'(in_tile_row) < CMPW'(MAX_ROWS));
    end
  end

  // divider lanes: floor(a/d) = a/d for a >= 0, ~(~a/d) for a < 0
  assign a_in[LN_LEFT]   = QW'(in_rect_x);
  assign a_in[LN_RIGHT]  = QW'(in_rect_x) + $signed({5'b0, in_rect_w}) - 17'sd1;
  assign a_in[LN_TOP]    = QW'(in_rect_y);
  assign a_in[LN_BOTTOM] = QW'(in_rect_y) + $signed({5'b0, in_rect_h}) - 17'sd1;

  always_comb begin
    logic [DVS_W:0] sh;
    for (int l = 0; l < LANES; l++) begin
      sh = {rem_r[l], dvd_r[l][DVD_W-1]};
      if (sh >= {1'b0, ts_r}) begin
        rem_nxt[l] = DVS_W'(sh - {1'b0, ts_r});
        dvd_nxt[l] = {dvd_r[l][DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt[l] = sh[DVS_W-1:0];
        dvd_nxt[l] = {dvd_r[l][DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_tuser == KIND_QUERY) begin
      ts_r   <= (tile_size_r == '0) ? DVS_W'(1) : tile_size_r;
      dcnt_r <= '0;
      for (int l = 0; l < LANES; l++) begin
        neg_r[l] <= a_in[l][QW-1];
        dvd_r[l] <= a_in[l][QW-1] ? ~a_in[l][DVD_W-1:0] : a_in[l][DVD_W-1:0];
        rem_r[l] <= '0;
      end
    end else if (st_r == ST_DIV) begin
      dcnt_r <= dcnt_r + 1'b1;
      for (int l = 0; l < LANES; l++) begin
        dvd_r[l] <= dvd_nxt[l];
        rem_r[l] <= rem_nxt[l];
      end
    end
  end

  // clip the covered range to the map
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      q_s[l] = neg_r[l] ? CMPW'($signed(~{1'b0, dvd_r[l]}))
                        : CMPW'($signed({1'b0, dvd_r[l]}));
    end
    cols_s = (CMPW'(map_cols_r) > CMPW'(MAX_COLS)) ? CMPW'(MAX_COLS) : CMPW'(map_cols_r);
    rows_s = (CMPW'(map_rows_r) > CMPW'(MAX_ROWS)) ? CMPW'(MAX_ROWS) : CMPW'(map_rows_r);
    left_c   = (q_s[LN_LEFT] < 0) ? '0 : q_s[LN_LEFT];
    top_c    = (q_s[LN_TOP] < 0) ? '0 : q_s[LN_TOP];
    right_c  = (q_s[LN_RIGHT] > cols_s - 1) ? cols_s - 1 : q_s[LN_RIGHT];
    bottom_c = (q_s[LN_BOTTOM] > rows_s - 1) ? rows_s - 1 : q_s[LN_BOTTOM];
    empty_c  = (cols_s == '0) || (rows_s == '0) || (left_c > right_c) || (top_c > bottom_c);
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_CLIP) begin
      left_r   <= left_c[CA_W-1:0];
      right_r  <= right_c[CA_W-1:0];
      top_r    <= top_c[RA_W-1:0];
      bottom_r <= bottom_c[RA_W-1:0];
      empty_r  <= empty_c;
    end
  end

  // row scan, one row read per cycle
  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      scan_mask[i] = (CMPW'(i) >= CMPW'(left_r)) && (CMPW'(i) <= CMPW'(right_r));
    end
  end

  assign issue = (row_r <= {1'b0, bottom_r}) && !hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_r <= 1'b0;
    end else if (st_r == ST_SCAN) begin
      issued_r <= issue;
    end else begin
      issued_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_CLIP) begin
      row_r <= {1'b0, top_c[RA_W-1:0]};
      hit_r <= 1'b0;
    end else if (st_r == ST_SCAN) begin
      if (issue) row_r <= row_r + 1'b1;
      if (issued_r && ((rdata_r & scan_mask) != '0)) hit_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_hit_r <= last_query_r && hit_r && !empty_r;
  end

  always_ff @(posedge clk) begin
    if (accept) last_query_r <= (in_tuser == KIND_QUERY);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW-1)'(0), out_hit_r};

endmodule
